// ===== design/wit_pkg.sv =====
// ----------------------------------------------------------------------------
// wit_pkg: shared constants and types for the Winograd input transform
// Field widths, tile size codes, size classes and the per-class row weights.
// ----------------------------------------------------------------------------
package wit_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int NUM_LANES    = 8;
  localparam int COEF_WIDTH   = 24;
  localparam int WEIGHT_WIDTH = 8;
  localparam int TILE_WIDTH   = 4;

  // The largest row weight sum is 100, so a sum of eight products fits here.
  localparam int ACC_WIDTH = SAMPLE_WIDTH + WEIGHT_WIDTH;
  localparam int EXT_WIDTH = (ACC_WIDTH > COEF_WIDTH) ? ACC_WIDTH : COEF_WIDTH;

  localparam int IN_DATA_WIDTH  = ((SAMPLE_WIDTH * NUM_LANES + 7) / 8) * 8;
  localparam int OUT_DATA_WIDTH = ((COEF_WIDTH * NUM_LANES + 7) / 8) * 8;

  localparam logic [TILE_WIDTH-1:0] TILE_F23   = 4'd4;
  localparam logic [TILE_WIDTH-1:0] TILE_F43   = 4'd6;
  localparam logic [TILE_WIDTH-1:0] TILE_F63   = 4'd8;
  localparam logic [TILE_WIDTH-1:0] TILE_RESET = TILE_F63;

  typedef enum logic [1:0] {
    CLS_F23,
    CLS_F43,
    CLS_F63,
    CLS_NONE
  } wit_cls_t;

  typedef logic signed [WEIGHT_WIDTH-1:0] wit_weight_t;

  // [class][output row][input element]
  localparam wit_weight_t WT_ROWS [3][NUM_LANES][NUM_LANES] = '{
    '{
      '{  8'sd1,  8'sd0, -8'sd1,  8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0 },
      '{  8'sd0,  8'sd1,  8'sd1,  8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0 },
      '{  8'sd0, -8'sd1,  8'sd1,  8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0 },
      '{  8'sd0, -8'sd1,  8'sd0,  8'sd1, 8'sd0, 8'sd0, 8'sd0, 8'sd0 },
      '{ 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0 },
      '{ 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0 },
      '{ 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0 },
      '{ 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0 }
    },
    '{
      '{  8'sd4,  8'sd0, -8'sd5,  8'sd0, 8'sd1, 8'sd0, 8'sd0, 8'sd0 },
      '{  8'sd0, -8'sd4, -8'sd4,  8'sd1, 8'sd1, 8'sd0, 8'sd0, 8'sd0 },
      '{  8'sd0,  8'sd4, -8'sd4, -8'sd1, 8'sd1, 8'sd0, 8'sd0, 8'sd0 },
      '{  8'sd0, -8'sd2, -8'sd1,  8'sd2, 8'sd1, 8'sd0, 8'sd0, 8'sd0 },
      '{  8'sd0,  8'sd2, -8'sd1, -8'sd2, 8'sd1, 8'sd0, 8'sd0, 8'sd0 },
      '{  8'sd0,  8'sd4,  8'sd0, -8'sd5, 8'sd0, 8'sd1, 8'sd0, 8'sd0 },
      '{ 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0 },
      '{ 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0 }
    },
    '{
      '{ 8'sd36,   8'sd0, -8'sd49,   8'sd0,  8'sd14,   8'sd0, -8'sd1, 8'sd0 },
      '{  8'sd0,  8'sd36,  8'sd36, -8'sd13, -8'sd13,   8'sd1,  8'sd1, 8'sd0 },
      '{  8'sd0, -8'sd36,  8'sd36,  8'sd13, -8'sd13,  -8'sd1,  8'sd1, 8'sd0 },
      '{  8'sd0,  8'sd18,   8'sd9, -8'sd20, -8'sd10,   8'sd2,  8'sd1, 8'sd0 },
      '{  8'sd0, -8'sd18,   8'sd9,  8'sd20, -8'sd10,  -8'sd2,  8'sd1, 8'sd0 },
      '{  8'sd0,  8'sd12,   8'sd4, -8'sd15,  -8'sd5,   8'sd3,  8'sd1, 8'sd0 },
      '{  8'sd0, -8'sd12,   8'sd4,  8'sd15,  -8'sd5,  -8'sd3,  8'sd1, 8'sd0 },
      '{  8'sd0, -8'sd36,   8'sd0,  8'sd49,   8'sd0, -8'sd14,  8'sd0, 8'sd1 }
    }
  };

endpackage

// ===== design/winograd_input_transform_top.sv =====
// ----------------------------------------------------------------------------
// winograd_input_transform_top: 1-D Winograd input transform, 8-lane column
// Four-stage pipeline computing B-transpose times one column per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one column of eight signed samples per transfer on in_tdata.
//   out_*  : eight transformed coefficients on out_tdata, the unsupported
//            flag on out_tuser; one result per input transfer, in order.
//   cfg_*  : cfg_wr_en writes cfg_wr_data into the tile size register
//            (4, 6 or 8). Write it only while no column is in flight.
// Path: an accepted column passes through the input register, then the weighted
//   products, partial sums, and final sum and clamp registers to out_tvalid.
// Throughput: one column per cycle while out_tready is high; the four register stages set the latency.
// Reset: all stage valids clear, tile size returns to 8.
// Stall: each stage advances when it is empty or the next one advances, so
//   bubbles collapse while out_tready is low; with all four stages full,
//   in_tready drops and every stage holds its data.
// Unsupported tile size: coefficients read zero and out_tuser is 1.
module winograd_input_transform_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // tile_size[3:0]
  input  logic                                cfg_wr_en,
  input  logic [wit_pkg::TILE_WIDTH-1:0]      cfg_wr_data,
  // sample_0 .. sample_7, lowest bits first
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [wit_pkg::IN_DATA_WIDTH-1:0]   in_tdata,
  // coef_0 .. coef_7, lowest bits first
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [wit_pkg::OUT_DATA_WIDTH-1:0]  out_tdata,
  // unsupported
  output logic                                out_tuser
);

  localparam int SW = wit_pkg::SAMPLE_WIDTH;
  localparam int NL = wit_pkg::NUM_LANES;
  localparam int AW = wit_pkg::ACC_WIDTH;
  localparam int EW = wit_pkg::EXT_WIDTH;
  localparam int CW = wit_pkg::COEF_WIDTH;

  localparam logic signed [EW-1:0] COEF_MAX =
    {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [EW-1:0] COEF_MIN =
    {{(EW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic [wit_pkg::TILE_WIDTH-1:0] tile_size_r;

  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

  logic                     s1_vld_r;
  wit_pkg::wit_cls_t        s1_cls_r;
  logic signed [SW-1:0]     s1_smp_r [NL];

  logic                     s2_vld_r;
  logic                     s2_uns_r;
  logic signed [AW-1:0]     s2_prod_r   [NL][NL];
  logic signed [AW-1:0]     s2_prod_nxt [NL][NL];

  logic                     s3_vld_r;
  logic                     s3_uns_r;
  logic signed [AW-1:0]     s3_part_r   [NL][2];
  logic signed [AW-1:0]     s3_part_nxt [NL][2];

  logic                     out_vld_r;
  logic                     out_uns_r;
  logic signed [CW-1:0]     out_coef_r   [NL];
  logic signed [CW-1:0]     out_coef_nxt [NL];

  wit_pkg::wit_cls_t        in_cls;
  logic signed [SW-1:0]     in_smp [NL];

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_size_r <= wit_pkg::TILE_RESET;
    end else if (cfg_wr_en) begin
      tile_size_r <= cfg_wr_data;
    end
  end

  always_comb begin
    case (tile_size_r)
      wit_pkg::TILE_F23: in_cls = wit_pkg::CLS_F23;
      wit_pkg::TILE_F43: in_cls = wit_pkg::CLS_F43;
      wit_pkg::TILE_F63: in_cls = wit_pkg::CLS_F63;
      default:           in_cls = wit_pkg::CLS_NONE;
    endcase
  end

  always_comb begin
    for (int c = 0; c < NL; c++) begin
      in_smp[c] = signed'(in_tdata[c*SW +: SW]);
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: a stage advances when empty or when its successor advances
  // --------------------------------------------------------------------------
  assign s4_rdy    = !out_vld_r || out_tready;
  assign s3_rdy    = !s3_vld_r  || s4_rdy;
  assign s2_rdy    = !s2_vld_r  || s3_rdy;
  assign s1_rdy    = !s1_vld_r  || s2_rdy;
  assign in_tready = s1_rdy;

  // --------------------------------------------------------------------------
  // Stage 1: capture column and size class
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_r <= in_tvalid;
    end
    if (s1_rdy && in_tvalid) begin
      s1_cls_r <= in_cls;
      s1_smp_r <= in_smp;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: weighted products
  // --------------------------------------------------------------------------
  always_comb begin
    wit_pkg::wit_weight_t wt;
    for (int r = 0; r < NL; r++) begin
      for (int c = 0; c < NL; c++) begin
        if (s1_cls_r == wit_pkg::CLS_NONE) begin
          wt = '0;
        end else begin
          wt = wit_pkg::WT_ROWS[s1_cls_r][r][c];
        end
        s2_prod_nxt[r][c] = AW'(s1_smp_r[c]) * AW'(wt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_vld_r <= s1_vld_r;
    end
    if (s2_rdy && s1_vld_r) begin
      s2_uns_r  <= (s1_cls_r == wit_pkg::CLS_NONE);
      s2_prod_r <= s2_prod_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: two partial sums of four products per row
  // --------------------------------------------------------------------------
  always_comb begin
    for (int r = 0; r < NL; r++) begin
      for (int h = 0; h < 2; h++) begin
        s3_part_nxt[r][h] = (s2_prod_r[r][4*h]   + s2_prod_r[r][4*h+1])
                          + (s2_prod_r[r][4*h+2] + s2_prod_r[r][4*h+3]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_vld_r <= s2_vld_r;
    end
    if (s3_rdy && s2_vld_r) begin
      s3_uns_r  <= s2_uns_r;
      s3_part_r <= s3_part_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: final sum, clamp to the coefficient range
  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [AW-1:0] sum;
    logic signed [EW-1:0] ext;
    for (int r = 0; r < NL; r++) begin
      sum = s3_part_r[r][0] + s3_part_r[r][1];
      ext = EW'(sum);
      if (ext > COEF_MAX) begin
        ext = COEF_MAX;
      end else if (ext < COEF_MIN) begin
        ext = COEF_MIN;
      end
      out_coef_nxt[r] = ext[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s4_rdy) begin
      out_vld_r <= s3_vld_r;
    end
    if (s4_rdy && s3_vld_r) begin
      out_uns_r  <= s3_uns_r;
      out_coef_r <= out_coef_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_uns_r;

  always_comb begin
    out_tdata = '0;
    for (int r = 0; r < NL; r++) begin
      out_tdata[r*CW +: CW] = out_coef_r[r];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An unsupported size must drive every coefficient to zero.
  a_uns_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("unsupported tile size produced nonzero coefficients");

  // With every stage full and the sink stalled, no new column may enter.
  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s2_vld_r && s3_vld_r && out_vld_r && !out_tready |-> !in_tready)
    else $error("input accepted while pipeline full and stalled");

  // A stalled stage 3 holding valid data must not change under the stall.
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r && !s4_rdy |=> s3_vld_r && $stable(s3_uns_r))
    else $error("stage 3 lost its item during a stall");

endmodule

// ===== dv/wit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wit_checker: in-order scoreboard for the Winograd input transform
// Follows the tile size through register writes, computes the transformed
// column at every input transfer and compares each output transfer with the
// oldest outstanding column, coefficient by coefficient and the flag.
// ----------------------------------------------------------------------------
module wit_checker
  import wit_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [TILE_WIDTH-1:0]      cfg_wr_data,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [IN_DATA_WIDTH-1:0]   in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [OUT_DATA_WIDTH-1:0]  out_tdata,
  input  logic                       out_tuser,
  output int                         mismatches,
  output int                         expected_left
);

  typedef struct packed {
    logic                                  unsupported;
    logic [NUM_LANES-1:0][COEF_WIDTH-1:0]  coef;
  } column_coefs_t;

  // B-transpose rows per size class: [class][output row][input element]
  localparam int ROW_WEIGHTS [3][NUM_LANES][NUM_LANES] = '{
    '{
      '{ 1,  0, -1,  0, 0, 0, 0, 0 },
      '{ 0,  1,  1,  0, 0, 0, 0, 0 },
      '{ 0, -1,  1,  0, 0, 0, 0, 0 },
      '{ 0, -1,  0,  1, 0, 0, 0, 0 },
      '{ 0,  0,  0,  0, 0, 0, 0, 0 },
      '{ 0,  0,  0,  0, 0, 0, 0, 0 },
      '{ 0,  0,  0,  0, 0, 0, 0, 0 },
      '{ 0,  0,  0,  0, 0, 0, 0, 0 }
    },
    '{
      '{ 4,  0, -5,  0, 1, 0, 0, 0 },
      '{ 0, -4, -4,  1, 1, 0, 0, 0 },
      '{ 0,  4, -4, -1, 1, 0, 0, 0 },
      '{ 0, -2, -1,  2, 1, 0, 0, 0 },
      '{ 0,  2, -1, -2, 1, 0, 0, 0 },
      '{ 0,  4,  0, -5, 0, 1, 0, 0 },
      '{ 0,  0,  0,  0, 0, 0, 0, 0 },
      '{ 0,  0,  0,  0, 0, 0, 0, 0 }
    },
    '{
      '{ 36,   0, -49,   0,  14,   0, -1, 0 },
      '{  0,  36,  36, -13, -13,   1,  1, 0 },
      '{  0, -36,  36,  13, -13,  -1,  1, 0 },
      '{  0,  18,   9, -20, -10,   2,  1, 0 },
      '{  0, -18,   9,  20, -10,  -2,  1, 0 },
      '{  0,  12,   4, -15,  -5,   3,  1, 0 },
      '{  0, -12,   4,  15,  -5,  -3,  1, 0 },
      '{  0, -36,   0,  49,   0, -14,  0, 1 }
    }
  };

  logic [TILE_WIDTH-1:0] tile_size;
  column_coefs_t         coef_q [$];
  int                    fail_count = 0;

  assign mismatches = fail_count;

  function automatic column_coefs_t transform_column(input logic [TILE_WIDTH-1:0]    size,
                                                     input logic [IN_DATA_WIDTH-1:0] col);
    column_coefs_t res;
    wit_cls_t      cls;
    longint        acc;
    longint        lim;
    res = '0;
    lim = longint'(1) <<< (COEF_WIDTH - 1);
    case (size)
      TILE_F23: cls = CLS_F23;
      TILE_F43: cls = CLS_F43;
      TILE_F63: cls = CLS_F63;
      default:  cls = CLS_NONE;
    endcase
    if (cls == CLS_NONE) begin
      res.unsupported = 1'b1;
    end else begin
      for (int r = 0; r < NUM_LANES; r++) begin
        acc = 0;
        for (int c = 0; c < NUM_LANES; c++) begin
          acc += longint'(ROW_WEIGHTS[int'(cls)][r][c]) *
                 longint'($signed(col[c*SAMPLE_WIDTH +: SAMPLE_WIDTH]));
        end
        // saturate; only reachable with wider samples
        if (acc > lim - 1) begin
          acc = lim - 1;
        end else if (acc < -lim) begin
          acc = -lim;
        end
        res.coef[r] = acc[COEF_WIDTH-1:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    column_coefs_t want;
    if (!rst_n) begin
      tile_size <= TILE_RESET;
      coef_q.delete();
      expected_left <= 0;
    end else begin
      if (cfg_wr_en) begin
        tile_size <= cfg_wr_data;
      end
      if (out_tvalid && out_tready) begin
        if (coef_q.size() == 0) begin
          $error("output transfer with no column outstanding");
          fail_count++;
        end else begin
          want = coef_q.pop_front();
          for (int i = 0; i < NUM_LANES; i++) begin
            if (out_tdata[i*COEF_WIDTH +: COEF_WIDTH] !== want.coef[i]) begin
              $error("coef_%0d: expected %0d, got %0d", i, $signed(want.coef[i]),
                     $signed(out_tdata[i*COEF_WIDTH +: COEF_WIDTH]));
              fail_count++;
            end
          end
          if (out_tuser !== want.unsupported) begin
            $error("unsupported: expected %0d, got %0d", want.unsupported, out_tuser);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        coef_q.push_back(transform_column(tile_size, in_tdata));
      end
      expected_left <= coef_q.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top for winograd_input_transform_top
// Drives directed extreme columns for every tile size, then random phases
// with random tile sizes, bursty input and a varying output stall pattern.
// ----------------------------------------------------------------------------
module tb;
  import wit_pkg::*;

  localparam int LATENCY        = 4;
  localparam int RANDOM_COLUMNS = 1350;

  localparam logic [SAMPLE_WIDTH-1:0] S_MAX = 16'h7FFF;
  localparam logic [SAMPLE_WIDTH-1:0] S_MIN = 16'h8000;

  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PERIODIC
  } ready_mode_t;

  typedef enum int {
    COL_ZERO,
    COL_ALL_MAX,
    COL_ALL_MIN,
    COL_MAX_MIN,
    COL_MIN_MAX
  } col_pattern_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [TILE_WIDTH-1:0]      cfg_wr_data;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [IN_DATA_WIDTH-1:0]   in_tdata;
  logic                       out_tvalid;
  logic                       out_tready;
  logic [OUT_DATA_WIDTH-1:0]  out_tdata;
  logic                       out_tuser;

  int          mismatches;
  int          expected_left;
  int          burst_left = 0;
  int          gap_max    = 0;
  ready_mode_t ready_mode = RDY_ALWAYS;
  int          ready_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  winograd_input_transform_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  wit_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .mismatches    (mismatches),
    .expected_left (expected_left)
  );

  // Output stall pattern: switch at random between four ready modes.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      case (ready_mode)
        RDY_ALWAYS: out_tready <= 1'b1;
        RDY_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: out_tready <= ($urandom_range(0, 5) == 0);
        default:    out_tready <= (ready_left % 4 != 0);
      endcase
    end
    if (ready_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      ready_left <= $urandom_range(16, 160);
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  function automatic logic [IN_DATA_WIDTH-1:0] pattern_column(input col_pattern_t kind);
    logic [IN_DATA_WIDTH-1:0] col;
    col = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      case (kind)
        COL_ALL_MAX: col[i*SAMPLE_WIDTH +: SAMPLE_WIDTH] = S_MAX;
        COL_ALL_MIN: col[i*SAMPLE_WIDTH +: SAMPLE_WIDTH] = S_MIN;
        COL_MAX_MIN: col[i*SAMPLE_WIDTH +: SAMPLE_WIDTH] = (i % 2 == 0) ? S_MAX : S_MIN;
        COL_MIN_MAX: col[i*SAMPLE_WIDTH +: SAMPLE_WIDTH] = (i % 2 == 0) ? S_MIN : S_MAX;
        default:     col[i*SAMPLE_WIDTH +: SAMPLE_WIDTH] = '0;
      endcase
    end
    return col;
  endfunction

  // Mostly full-range samples, with extremes and small values mixed in.
  function automatic logic [IN_DATA_WIDTH-1:0] random_column();
    logic [IN_DATA_WIDTH-1:0] col;
    logic [SAMPLE_WIDTH-1:0]  s;
    for (int i = 0; i < NUM_LANES; i++) begin
      case ($urandom_range(0, 9))
        0:       s = S_MAX;
        1:       s = S_MIN;
        2:       s = SAMPLE_WIDTH'($urandom_range(0, 15) - 8);
        default: s = SAMPLE_WIDTH'($urandom);
      endcase
      col[i*SAMPLE_WIDTH +: SAMPLE_WIDTH] = s;
    end
    return col;
  endfunction

  task automatic send_column(input logic [IN_DATA_WIDTH-1:0] col);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= col;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every outstanding column has come back.
  task automatic drain();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_tile(input logic [TILE_WIDTH-1:0] size);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [TILE_WIDTH-1:0] directed_sizes [4];
    logic [TILE_WIDTH-1:0] size;
    int                    sent;
    int                    phase;
    int                    count;

    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= TILE_RESET;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset size first, then every size and both ends of the register.
    for (int k = 0; k < 5; k++) send_column(pattern_column(col_pattern_t'(k)));
    directed_sizes = '{TILE_F23, TILE_F43, 4'hF, 4'h0};
    foreach (directed_sizes[j]) begin
      drain();
      write_tile(directed_sizes[j]);
      for (int k = 0; k < ((j < 2) ? 5 : 2); k++) begin
        send_column(pattern_column(col_pattern_t'((j < 2) ? k : k + 1)));
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_COLUMNS) begin
      if (phase == 3) begin
        size = 4'hF;
      end else if (phase == 7) begin
        size = 4'h0;
      end else if ($urandom_range(0, 5) == 0) begin
        size = TILE_WIDTH'($urandom_range(0, 15));
      end else begin
        case ($urandom_range(0, 2))
          0:       size = TILE_F23;
          1:       size = TILE_F43;
          default: size = TILE_F63;
        endcase
      end
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      count   = $urandom_range(60, 140);
      drain();
      write_tile(size);
      repeat (count) send_column(random_column());
      sent += count;
      phase++;
    end

    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
